[hdl/hwr_pkg.sv]
// ---------------------------------------------------------------------------
// hwr_pkg
// Types and constants shared by the hue wheel RGB PWM driver.
// ---------------------------------------------------------------------------
package hwr_pkg;

  localparam int HUE_W     = 9;
  localparam int DUTY_W    = 8;
  localparam int CNT_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int K_W       = 6;

  // Reciprocal of the sector width: floor(x / 60) == (x * RECIP) >> RECIP_SHIFT
  // for every x below 23831, well above the largest ramp product (60 * 255).
  localparam int RECIP_SHIFT = 20;
  localparam int RECIP_W     = 15;
  localparam logic [RECIP_W-1:0] RECIP = 15'd17477;
  localparam int SCALE_W     = DUTY_W + RECIP_W;
  localparam int PROD_W      = SCALE_W + K_W;

  localparam logic [HUE_W-1:0] SECTOR1  = 9'd60;
  localparam logic [HUE_W-1:0] SECTOR2  = 9'd120;
  localparam logic [HUE_W-1:0] SECTOR3  = 9'd180;
  localparam logic [HUE_W-1:0] SECTOR4  = 9'd240;
  localparam logic [HUE_W-1:0] SECTOR5  = 9'd300;
  localparam logic [HUE_W:0]   HUE_FULL = 10'd360;

  localparam logic [DUTY_W-1:0] PHASE_STEP  = 8'd8;
  localparam logic [DUTY_W-1:0] SET_LIMIT   = 8'd8;
  localparam logic [DUTY_W-1:0] GREEN_START = 8'(255 / 3);
  localparam logic [DUTY_W-1:0] BLUE_START  = 8'(255 / 3 * 2);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PEAK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INC   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DWELL = 2'd3;

  localparam logic [DUTY_W-1:0] PEAK_RST  = 8'd255;
  localparam logic [DUTY_W-1:0] FLOOR_RST = 8'd0;
  localparam logic [HUE_W-1:0]  INC_RST   = 9'd16;
  localparam logic [CNT_W-1:0]  DWELL_RST = 16'd2550;

  typedef struct packed {
    logic [DUTY_W-1:0] red;
    logic [DUTY_W-1:0] green;
    logic [DUTY_W-1:0] blue;
  } duty_t;

  typedef struct packed {
    logic              red_on;
    logic              green_on;
    logic              blue_on;
    logic [HUE_W-1:0]  hue_now;
    logic [DUTY_W-1:0] red_duty;
    logic [DUTY_W-1:0] green_duty;
    logic [DUTY_W-1:0] blue_duty;
  } result_t;

endpackage

[hdl/hwr_duty.sv]
// ---------------------------------------------------------------------------
// hwr_duty
// Six-sector hue wheel: red, green and blue duty levels for one hue.
// ---------------------------------------------------------------------------
module hwr_duty (
  input  logic [hwr_pkg::HUE_W-1:0]   hue,
  input  logic [hwr_pkg::DUTY_W-1:0]  peak_level,
  input  logic [hwr_pkg::DUTY_W-1:0]  floor_level,
  input  logic [hwr_pkg::SCALE_W-1:0] scale,
  input  logic                        neg,
  output hwr_pkg::duty_t              duty
);
  import hwr_pkg::*;

  logic [HUE_W-1:0]  k_full;
  logic [K_W-1:0]    k;
  logic [PROD_W-1:0] prod;
  logic [DUTY_W-1:0] q;
  logic [DUTY_W-1:0] ramp;

  // Ramp position inside the sector, 0..60
  always_comb begin
    if (hue < SECTOR1) begin
      k_full = hue;
    end else if (hue < SECTOR2) begin
      k_full = SECTOR2 - hue;
    end else if (hue < SECTOR3) begin
      k_full = hue - SECTOR2;
    end else if (hue < SECTOR4) begin
      k_full = SECTOR4 - hue;
    end else if (hue < SECTOR5) begin
      k_full = hue - SECTOR4;
    end else begin
      k_full = HUE_FULL[HUE_W-1:0] - hue;
    end
  end

  assign k    = k_full[K_W-1:0];
  // scale already holds |peak - floor| times the reciprocal of 60
  assign prod = PROD_W'(k) * PROD_W'(scale);
  assign q    = prod[RECIP_SHIFT +: DUTY_W];
  assign ramp = neg ? (floor_level - q) : (floor_level + q);

  always_comb begin
    if (hue < SECTOR1) begin
      duty = '{red: peak_level, green: ramp, blue: floor_level};
    end else if (hue < SECTOR2) begin
      duty = '{red: ramp, green: peak_level, blue: floor_level};
    end else if (hue < SECTOR3) begin
      duty = '{red: floor_level, green: peak_level, blue: ramp};
    end else if (hue < SECTOR4) begin
      duty = '{red: floor_level, green: ramp, blue: peak_level};
    end else if (hue < SECTOR5) begin
      duty = '{red: ramp, green: floor_level, blue: peak_level};
    end else begin
      duty = '{red: peak_level, green: floor_level, blue: ramp};
    end
  end

endmodule

[hdl/hwr_skid.sv]
// ---------------------------------------------------------------------------
// hwr_skid
// Two-entry result buffer between the state update and the output channel.
// ---------------------------------------------------------------------------
module hwr_skid (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  hwr_pkg::result_t push_data,
  output logic             full,
  output logic             out_valid,
  input  logic             out_stall,
  output hwr_pkg::result_t out_data
);
  import hwr_pkg::*;

  result_t    entry0;
  result_t    entry1;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && !out_stall;
  assign out_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign out_data  = entry0;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      case ({push, pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case ({push, pop})
      2'b10: begin
        if (count == 2'd0) begin
          entry0 <= push_data;
        end else begin
          entry1 <= push_data;
        end
      end
      2'b01: begin
        entry0 <= entry1;
      end
      2'b11: begin
        // one entry held: it leaves as the new one arrives
        entry0 <= push_data;
      end
      default: begin
        entry0 <= entry0;
      end
    endcase
  end

endmodule

[hdl/hue_wheel_rgb_pwm.sv]
// ---------------------------------------------------------------------------
// hue_wheel_rgb_pwm
// Hue-cycling RGB LED driver with three phase-shifted software PWM channels.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / tick): each transfer is one step;
//   tick = 1 advances one microsecond, tick = 0 just reports the state.
//   Output channel (out_valid / out_stall): one result per input transfer,
//   in order, showing LED levels, the hue in effect and the three duties
//   as they stand after that step.
//   Configuration: cfg_write with cfg_index selects peak, floor, hue step
//   or dwell length; write only while no results are outstanding.
//   out_valid rises in the cycle after an input transfer; throughput is one
//   item per cycle while in_stall is low. Each step is settled in one pass
//   through the phase compares and the wheel's single 6x23 ramp multiplier.
//   Reset: registers return to 255 / 0 / 16 / 2550, hue 0 with duties
//   255, 0, 0, phases 0 / 85 / 170, all LEDs dark, no results pending.
//   A two-entry result buffer absorbs output stalls; in_stall rises only
//   when both entries are held.
// ---------------------------------------------------------------------------
module hue_wheel_rgb_pwm (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [hwr_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hwr_pkg::CFG_DAT_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          tick,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          red_on,
  output logic                          green_on,
  output logic                          blue_on,
  output logic [hwr_pkg::HUE_W-1:0]     hue_now,
  output logic [hwr_pkg::DUTY_W-1:0]    red_duty,
  output logic [hwr_pkg::DUTY_W-1:0]    green_duty,
  output logic [hwr_pkg::DUTY_W-1:0]    blue_duty
);
  import hwr_pkg::*;

  // Configuration
  logic [DUTY_W-1:0]  peak_level;
  logic [DUTY_W-1:0]  floor_level;
  logic [HUE_W-1:0]   hue_increment;
  logic [CNT_W-1:0]   dwell_ticks;
  logic [SCALE_W-1:0] scale;
  logic               neg;
  logic [DUTY_W-1:0]  peak_next;
  logic [DUTY_W-1:0]  floor_next;
  logic [DUTY_W-1:0]  mag_next;

  // Step state
  logic [HUE_W-1:0]  hue_deg;
  logic [CNT_W-1:0]  dwell_count;
  logic [DUTY_W-1:0] red_phase;
  logic [DUTY_W-1:0] green_phase;
  logic [DUTY_W-1:0] blue_phase;
  duty_t             duty;
  logic [2:0]        leds;

  logic [HUE_W-1:0]  hue_deg_next;
  logic [CNT_W-1:0]  dwell_count_next;
  logic [DUTY_W-1:0] red_phase_next;
  logic [DUTY_W-1:0] green_phase_next;
  logic [DUTY_W-1:0] blue_phase_next;
  duty_t             duty_next;
  logic [2:0]        leds_next;

  logic [CNT_W:0]    count_inc;
  logic              dwell_end;
  logic [HUE_W:0]    hue_sum;
  logic [HUE_W-1:0]  hue_step;
  duty_t             wheel_duty;
  logic              accept;
  logic              full;
  result_t           result;
  result_t           out_data;

  assign accept   = in_valid && !in_stall;
  assign in_stall = full;

  // Register writes; the ramp scale is loaded at the same edge as peak and floor
  assign peak_next  = (cfg_write && cfg_index == REG_PEAK) ? cfg_data[DUTY_W-1:0] : peak_level;
  assign floor_next = (cfg_write && cfg_index == REG_FLOOR) ? cfg_data[DUTY_W-1:0]
                                                            : floor_level;
  assign mag_next   = (floor_next > peak_next) ? (floor_next - peak_next)
                                               : (peak_next - floor_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      peak_level    <= PEAK_RST;
      floor_level   <= FLOOR_RST;
      hue_increment <= INC_RST;
      dwell_ticks   <= DWELL_RST;
      scale         <= SCALE_W'(PEAK_RST - FLOOR_RST) * SCALE_W'(RECIP);
      neg           <= 1'b0;
    end else begin
      peak_level  <= peak_next;
      floor_level <= floor_next;
      scale       <= SCALE_W'(mag_next) * SCALE_W'(RECIP);
      neg         <= (floor_next > peak_next);
      if (cfg_write && cfg_index == REG_INC) begin
        hue_increment <= cfg_data[HUE_W-1:0];
      end
      if (cfg_write && cfg_index == REG_DWELL) begin
        dwell_ticks <= cfg_data[CNT_W-1:0];
      end
    end
  end

  // Next hue and its duties
  assign hue_sum  = {1'b0, hue_deg} + {1'b0, hue_increment};
  assign hue_step = (hue_sum >= HUE_FULL) ? '0 : hue_sum[HUE_W-1:0];

  hwr_duty u_duty (
    .hue         (hue_step),
    .peak_level  (peak_level),
    .floor_level (floor_level),
    .scale       (scale),
    .neg         (neg),
    .duty        (wheel_duty)
  );

  assign count_inc = {1'b0, dwell_count} + 17'd1;
  assign dwell_end = (count_inc >= {1'b0, dwell_ticks});

  always_comb begin
    hue_deg_next     = hue_deg;
    dwell_count_next = dwell_count;
    red_phase_next   = red_phase;
    green_phase_next = green_phase;
    blue_phase_next  = blue_phase;
    duty_next        = duty;
    leds_next        = leds;
    if (tick) begin
      // set wins over clear
      leds_next[0] = (red_phase <= SET_LIMIT) || (leds[0] && !(red_phase > duty.red));
      leds_next[1] = (green_phase <= SET_LIMIT) ||
                     (leds[1] && !(green_phase > duty.green));
      leds_next[2] = (blue_phase <= SET_LIMIT) || (leds[2] && !(blue_phase > duty.blue));
      if (dwell_end) begin
        hue_deg_next     = hue_step;
        dwell_count_next = '0;
        red_phase_next   = '0;
        green_phase_next = GREEN_START;
        blue_phase_next  = BLUE_START;
        duty_next        = wheel_duty;
      end else begin
        dwell_count_next = count_inc[CNT_W-1:0];
        red_phase_next   = red_phase + PHASE_STEP;
        green_phase_next = green_phase + PHASE_STEP;
        blue_phase_next  = blue_phase + PHASE_STEP;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_deg     <= '0;
      dwell_count <= '0;
      red_phase   <= '0;
      green_phase <= GREEN_START;
      blue_phase  <= BLUE_START;
      duty        <= '{red: PEAK_RST, green: FLOOR_RST, blue: FLOOR_RST};
      leds        <= '0;
    end else if (accept) begin
      hue_deg     <= hue_deg_next;
      dwell_count <= dwell_count_next;
      red_phase   <= red_phase_next;
      green_phase <= green_phase_next;
      blue_phase  <= blue_phase_next;
      duty        <= duty_next;
      leds        <= leds_next;
    end
  end

  assign result = '{
    red_on:     leds_next[0],
    green_on:   leds_next[1],
    blue_on:    leds_next[2],
    hue_now:    hue_deg_next,
    red_duty:   duty_next.red,
    green_duty: duty_next.green,
    blue_duty:  duty_next.blue
  };

  hwr_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (accept),
    .push_data (result),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  assign red_on     = out_data.red_on;
  assign green_on   = out_data.green_on;
  assign blue_on    = out_data.blue_on;
  assign hue_now    = out_data.hue_now;
  assign red_duty   = out_data.red_duty;
  assign green_duty = out_data.green_duty;
  assign blue_duty  = out_data.blue_duty;

endmodule
